[hw/rtl/taylor_sin_cos_tan_core_assert.svh]
// Assertion macros used by the core, which checks itself.
`ifndef TAYLOR_SIN_COS_TAN_CORE_ASSERT_SVH
`define TAYLOR_SIN_COS_TAN_CORE_ASSERT_SVH

// Checked property, switched off while reset is high.
`define TSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define TSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/tsc_pkg.sv]
package tsc_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ANGLE_W   = 31;
  localparam int VAL_W     = 32;
  localparam int TERM_W    = 32;
  localparam int X2_W      = 33;
  localparam int PROD_W    = 36;
  localparam int ACC_W     = 36;
  localparam int MLO_W     = 19;
  localparam int MHI_W     = 18;
  localparam int DIV_STEPS = 32;

  localparam logic [1:0] OP_SIN = 2'd0;
  localparam logic [1:0] OP_COS = 2'd1;
  localparam logic [1:0] OP_TAN = 2'd2;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [1:0]                opcode;
  } tsc_cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    overflow;
  } tsc_res_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] opcode;
    logic       xneg;
  } tsc_meta_t;

  typedef struct packed {
    logic                    valid;
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] base_val;
    logic                    neg;
    logic                    sneg;
    logic                    big;
    logic                    bzero;
    logic [VAL_W-1:0]        divisor;
    logic [VAL_W-1:0]        rem;
    logic [VAL_W-1:0]        low;
    logic [VAL_W-1:0]        quo;
  } tsc_div_t;

  localparam logic signed [ACC_W-1:0] ACC_S32_MAX = 36'sd2147483647;
  localparam logic signed [ACC_W-1:0] ACC_S32_MIN = -36'sd2147483648;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > ACC_S32_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < ACC_S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/tsc_series_cell.sv]
module tsc_series_cell #(
  parameter int K    = 0,
  parameter int BASE = 1
) (
  input  logic                              clk,
  input  logic [tsc_pkg::TERM_W-1:0]        t_in,
  input  logic [tsc_pkg::X2_W-1:0]          x2_in,
  input  logic signed [tsc_pkg::ACC_W-1:0]  acc_in,
  output logic [tsc_pkg::TERM_W-1:0]        t_out,
  output logic [tsc_pkg::X2_W-1:0]          x2_out,
  output logic signed [tsc_pkg::ACC_W-1:0]  acc_out
);
  import tsc_pkg::*;

  // Divisor of this step and its exact reciprocal for a PROD_W bit dividend.
  localparam int unsigned D     = (2 * K + BASE + 1) * (2 * K + BASE + 2);
  localparam int          L     = $clog2(D);
  localparam int          S     = PROD_W + L;
  localparam logic [95:0] TWO_S = 96'd1 << S;
  localparam logic [95:0] MULT  = (TWO_S + 96'(D) - 96'd1) / 96'(D);
  localparam logic [MLO_W-1:0] M_LO = MULT[MLO_W-1:0];
  localparam logic [MHI_W-1:0] M_HI = MULT[MLO_W +: MHI_W];
  localparam bit SUB = (K % 2) == 1;

  logic [TERM_W+X2_W-1:0]     prod;
  logic signed [ACC_W-1:0]    term_s;
  logic signed [ACC_W-1:0]    acc1_next;
  logic [PROD_W-1:0]          p1;
  logic [X2_W-1:0]            x2_1, x2_2;
  logic signed [ACC_W-1:0]    acc1, acc2;
  logic [PROD_W+MLO_W-1:0]    lo2;
  logic [PROD_W+MHI_W-1:0]    hi2;
  logic [95:0]                sum;

  always_comb begin
    prod   = (TERM_W+X2_W)'(t_in) * (TERM_W+X2_W)'(x2_in);
    term_s = $signed({{(ACC_W-TERM_W){1'b0}}, t_in});
    if (SUB) begin
      acc1_next = acc_in - term_s;
    end else begin
      acc1_next = acc_in + term_s;
    end
    sum = (96'(hi2) << MLO_W) + 96'(lo2);
  end

  always_ff @(posedge clk) begin
    p1      <= prod[FRAC_BITS +: PROD_W];
    x2_1    <= x2_in;
    acc1    <= acc1_next;
    lo2     <= (PROD_W+MLO_W)'(p1) * (PROD_W+MLO_W)'(M_LO);
    hi2     <= (PROD_W+MHI_W)'(p1) * (PROD_W+MHI_W)'(M_HI);
    x2_2    <= x2_1;
    acc2    <= acc1;
    t_out   <= sum[S +: TERM_W];
    x2_out  <= x2_2;
    acc_out <= acc2;
  end

endmodule

[hw/rtl/tsc_div_cell.sv]
module tsc_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  tsc_pkg::tsc_div_t d_in,
  output tsc_pkg::tsc_div_t d_out
);
  import tsc_pkg::*;

  tsc_div_t          d_next;
  logic [VAL_W-1:0]  r2;

  always_comb begin
    d_next = d_in;
    r2     = {d_in.rem[VAL_W-2:0], d_in.low[VAL_W-1]};
    d_next.low = d_in.low << 1;
    if (r2 >= d_in.divisor) begin
      d_next.rem = r2 - d_in.divisor;
      d_next.quo = {d_in.quo[VAL_W-2:0], 1'b1};
    end else begin
      d_next.rem = r2;
      d_next.quo = {d_in.quo[VAL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else begin
      d_out <= d_next;
    end
  end

endmodule

[hw/rtl/taylor_sin_cos_tan_core.sv]
// Path: the angle registers, the square and first-term registers, the rows of series cells,
// the saturation register, the divider input register, the divider cells and the result register.
// Throughput: one transaction per clock cycle; busy is always low and nothing stalls.
// Reset: synchronous, active high; it clears all valid bits so no result from before it appears after it.
// Each result is presented on res for exactly one cycle, marked by done; the receiver cannot stall.
module taylor_sin_cos_tan_core #(
  parameter int TERMS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tsc_pkg::tsc_cmd_t cmd,
  output logic              done,
  output tsc_pkg::tsc_res_t res
);
  import tsc_pkg::*;

  // Each series cell adds one term to the running sum and forms the next term, so a
  // chain of TERMS-1 cells leaves the last term to be added after the chain.
  localparam int DLY = 3 * (TERMS - 1);
  localparam int LAT = DLY + 37;
  localparam bit SUB_LAST = ((TERMS - 1) % 2) == 1;

  // The pipeline never stalls, so a new transaction may be offered every cycle.
  assign busy = 1'b0;

  // Stage zero: magnitude of the angle; its square is formed from it below.
  logic [31:0]            ax_full;
  logic [ANGLE_W-1:0]     ax;
  logic [2*ANGLE_W-1:0]   sq;
  logic [ANGLE_W-1:0]     ax0;
  logic [X2_W-1:0]        x2_0;
  tsc_meta_t              meta0;

  always_comb begin
    if (cmd.angle[ANGLE_W-1]) begin
      ax_full = 32'h8000_0000 - {1'b0, cmd.angle};
    end else begin
      ax_full = {1'b0, cmd.angle};
    end
    ax = ax_full[ANGLE_W-1:0];
    sq = (2*ANGLE_W)'(ax0) * (2*ANGLE_W)'(ax0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta0.valid <= 1'b0;
    end else begin
      meta0.valid  <= start && !busy;
      meta0.opcode <= cmd.opcode;
      meta0.xneg   <= cmd.angle[ANGLE_W-1];
    end
    ax0 <= ax;
  end

  // The square is formed here from ax0 and registered in x2_0 with the first sine term, so these
  // registers are loaded in the cycle after the angle registers.
  logic [TERM_W-1:0]        sin_t0, cos_t0;
  logic signed [ACC_W-1:0]  acc_zero;
  tsc_meta_t                meta1;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta1.valid <= 1'b0;
    end else begin
      meta1 <= meta0;
    end
    x2_0   <= sq[FRAC_BITS +: X2_W];
    sin_t0 <= TERM_W'(ax0);
  end

  assign cos_t0   = TERM_W'(1) << FRAC_BITS;
  assign acc_zero = '0;

  // Two rows of cells: the sine series starts from the angle, the cosine series from one.
  logic [TERM_W-1:0]        sin_t [TERMS];
  logic [TERM_W-1:0]        cos_t [TERMS];
  logic [X2_W-1:0]          sin_x2 [TERMS];
  logic [X2_W-1:0]          cos_x2 [TERMS];
  logic signed [ACC_W-1:0]  sin_a [TERMS];
  logic signed [ACC_W-1:0]  cos_a [TERMS];

  assign sin_t[0]  = sin_t0;
  assign cos_t[0]  = cos_t0;
  assign sin_x2[0] = x2_0;
  assign cos_x2[0] = x2_0;
  assign sin_a[0]  = acc_zero;
  assign cos_a[0]  = acc_zero;

  for (genvar i = 0; i < TERMS - 1; i++) begin : g_cell
    tsc_series_cell #(.K(i), .BASE(1)) u_sin (
      .clk    (clk),
      .t_in   (sin_t[i]),
      .x2_in  (sin_x2[i]),
      .acc_in (sin_a[i]),
      .t_out  (sin_t[i+1]),
      .x2_out (sin_x2[i+1]),
      .acc_out(sin_a[i+1])
    );
    tsc_series_cell #(.K(i), .BASE(0)) u_cos (
      .clk    (clk),
      .t_in   (cos_t[i]),
      .x2_in  (cos_x2[i]),
      .acc_in (cos_a[i]),
      .t_out  (cos_t[i+1]),
      .x2_out (cos_x2[i+1]),
      .acc_out(cos_a[i+1])
    );
  end

  // Side information travels alongside the cells in a plain delay line.
  tsc_meta_t meta_q [DLY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLY; i++) begin
        meta_q[i].valid <= 1'b0;
      end
    end else begin
      meta_q[0] <= meta1;
      for (int i = 1; i < DLY; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // Add the last term, restore the sign of the sine and saturate both sums to 32 bits.
  logic signed [ACC_W-1:0]  sin_last, cos_last, sin_term, cos_term, sin_signed;
  logic signed [VAL_W-1:0]  s_q, c_q;
  tsc_meta_t                meta_p1;

  always_comb begin
    sin_term = $signed({{(ACC_W-TERM_W){1'b0}}, sin_t[TERMS-1]});
    cos_term = $signed({{(ACC_W-TERM_W){1'b0}}, cos_t[TERMS-1]});
    if (SUB_LAST) begin
      sin_last = sin_a[TERMS-1] - sin_term;
      cos_last = cos_a[TERMS-1] - cos_term;
    end else begin
      sin_last = sin_a[TERMS-1] + sin_term;
      cos_last = cos_a[TERMS-1] + cos_term;
    end
    sin_signed = meta_q[DLY-1].xneg ? -sin_last : sin_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_p1.valid <= 1'b0;
    end else begin
      meta_p1 <= meta_q[DLY-1];
    end
    s_q <= sat32(sin_signed);
    c_q <= sat32(cos_last);
  end

  // Prepare the tangent division. The quotient fits 32 bits unless |sin| >= 16|cos|,
  // which is flagged up front, so the remainder starts from the top of |sin|.
  logic [VAL_W-1:0]  mag_s, mag_c;
  tsc_div_t          div_in;

  always_comb begin
    mag_s = s_q[VAL_W-1] ? 32'(-s_q) : 32'(s_q);
    mag_c = c_q[VAL_W-1] ? 32'(-c_q) : 32'(c_q);
    div_in.valid   = meta_p1.valid;
    div_in.opcode  = meta_p1.opcode;
    case (meta_p1.opcode)
      OP_SIN:  div_in.base_val = s_q;
      OP_COS:  div_in.base_val = c_q;
      default: div_in.base_val = '0;
    endcase
    div_in.neg     = s_q[VAL_W-1] ^ c_q[VAL_W-1];
    div_in.sneg    = s_q[VAL_W-1];
    div_in.big     = {4'b0, mag_s} >= {mag_c, 4'b0};
    div_in.bzero   = (mag_c == '0);
    div_in.divisor = mag_c;
    div_in.rem     = mag_s >> 4;
    div_in.low     = {mag_s[3:0], 28'b0};
    div_in.quo     = '0;
  end

  tsc_div_t div_q [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_q[0].valid <= 1'b0;
    end else begin
      div_q[0] <= div_in;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    tsc_div_cell u_div (
      .clk  (clk),
      .rst  (rst),
      .d_in (div_q[j]),
      .d_out(div_q[j+1])
    );
  end

  // Final selection: plain sine or cosine, or the tangent with its saturation rules.
  tsc_div_t          dv;
  logic [VAL_W:0]    limit;
  logic              sat;
  tsc_res_t          res_next;

  always_comb begin
    dv    = div_q[DIV_STEPS];
    limit = dv.neg ? 33'h1_0000_0000 >> 1 : (33'h1_0000_0000 >> 1) - 33'd1;
    sat   = dv.big || ({1'b0, dv.quo} > limit);
    res_next.value    = '0;
    res_next.overflow = 1'b0;
    case (dv.opcode)
      OP_SIN, OP_COS: begin
        res_next.value = dv.base_val;
      end
      OP_TAN: begin
        if (dv.bzero) begin
          res_next.value    = dv.sneg ? 32'sh8000_0000 : 32'sh7fff_ffff;
          res_next.overflow = 1'b1;
        end else if (sat) begin
          res_next.value    = dv.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
          res_next.overflow = 1'b1;
        end else begin
          res_next.value = dv.neg ? $signed(-dv.quo) : $signed(dv.quo);
        end
      end
      default: begin
        res_next.value = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv.valid;
    end
    res <= res_next;
  end

  // A value sits at one of the 32-bit limits when all bits below the sign differ from it.
  logic res_at_limit;
  assign res_at_limit = (res.value[VAL_W-2:0] == {(VAL_W-1){!res.value[VAL_W-1]}});

`include "taylor_sin_cos_tan_core_assert.svh"

  // Every accepted transaction is followed by its done strobe.
  `TSC_ASSERT(a_latency, (start && !busy) |-> ##LAT done, "result missing at fixed latency")
  // A flagged result is always saturated to one of the 32-bit limits.
  `TSC_ASSERT(a_ovf_sat, (done && res.overflow) |-> res_at_limit, "overflow without saturation")
  // The strobe never shows in the cycle after reset.
  `TSC_ASSERT_ALWAYS(a_rst_quiet, $past(rst) |-> !done, "result strobe after reset")

endmodule
